[src/tcce_pkg.sv]
// Shared constants, codes and control types of the text console cursor engine.
`default_nettype none

package tcce_pkg;

    // Tab stop spacing, and the width of the tab counter and column phase
    localparam int TAB_WIDTH = 8;
    localparam int TAB_CNT_W = 4;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 2'd3;

    // Register values after reset
    localparam logic       RST_ENABLE  = 1'b1;
    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [7:0] RST_ROWS    = 8'd25;
    localparam logic [7:0] RST_COLOR   = 8'd7;

    // Control characters
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Result kinds
    localparam logic KIND_CELL   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // accepted character while enabled
        logic emit_cell;    // write a cell into the output register
        logic emit_scroll;  // write a scroll command into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic enable;      // console active
        logic out_free;    // output register can take a result this cycle
        logic is_newline;  // incoming character is a newline
        logic is_write;    // incoming character writes cells (anything but newline or carriage return)
        logic wrap;        // cursor advance passes the last column
        logic bottom;      // moving down passes the last row
        logic tab_one;     // one cell left to write for this item
        logic tab_zero;    // no cell left to write for this item
    } t_status;

endpackage

`default_nettype wire

[src/tcce_ifs.sv]
// Valid/ready channel interfaces for characters in and screen results out.
`default_nettype none

interface tcce_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcce_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] glyph;
    logic [7:0] color;
    logic       last;

    modport source (output valid, output kind, output col, output row, output glyph,
                    output color, output last, input ready);
    modport sink   (input valid, input kind, input col, input row, input glyph,
                    input color, input last, output ready);
endinterface

`default_nettype wire

[src/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: controller plus datapath.
//
//  Channel   Direction  Handshake    Payload
//  i_char    in         valid/ready  char_code[7:0]
//  o_res     out        valid/ready  kind, col[7:0], row[7:0], glyph[7:0], color[7:0], last
//  i_cfg_*   in         write enable register index [1:0], data [7:0]
//
//  A printable character is accepted first, and its cell is then loaded into the output
//  register. A tab writes 8 - (column mod 8) cells, and each scroll adds one result; the
//  sequencer emits one result per cycle, while the output is not stalled, through the
//  single output register. Newline without scroll, carriage return and disabled input
//  produce no result. Reset is synchronous, active low, and needs no clearing pass.
//  A stalled output holds the sequencer; input is taken only while no item is in work.
`default_nettype none

module text_console_cursor_engine (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [tcce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tcce_char_if.sink                       i_char,
    tcce_res_if.source                      o_res
);

    tcce_pkg::t_cmd    cmd;
    tcce_pkg::t_status st;
    logic              in_ready;

    assign i_char.ready = in_ready;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    tcce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_char_code (i_char.char_code),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

[src/tcce_datapath.sv]
// Cursor, configuration registers, tab counter and result output register.
`default_nettype none

module tcce_datapath (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [tcce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [tcce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire  [7:0]                     i_char_code,
    input  wire  tcce_pkg::t_cmd           i_cmd,
    output tcce_pkg::t_status              o_st,
    tcce_res_if.source                     o_res
);

    localparam int TW = tcce_pkg::TAB_CNT_W;

    // Configuration registers
    logic       r_enable;
    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic [7:0] r_color;

    // Cursor and item state
    logic [7:0]    r_col, n_col;
    logic [7:0]    r_row, n_row;
    logic [TW-1:0] r_tab_ph, n_tab_ph;   // cursor column modulo the tab width
    logic [TW-1:0] r_tab_left, n_tab_left;
    logic [7:0]    r_glyph;

    // Output register
    logic       r_res_valid;
    logic       r_res_kind;
    logic [7:0] r_res_col;
    logic [7:0] r_res_row;
    logic [7:0] r_res_glyph;
    logic [7:0] r_res_color;
    logic       r_res_last;

    logic [7:0]    eff_cols;
    logic [7:0]    eff_rows;
    logic [8:0]    col_inc;
    logic [8:0]    row_inc;
    logic          wrap;
    logic          bottom;
    logic [7:0]    row_down;
    logic [TW-1:0] ph_inc;
    logic          is_nl;
    logic          is_cr;
    logic          is_tab;
    logic          out_free;

    // Treat a zero screen size as one
    assign eff_cols = (r_columns == 8'd0) ? 8'd1 : r_columns;
    assign eff_rows = (r_rows == 8'd0) ? 8'd1 : r_rows;

    // Advance tests against the screen edges
    assign col_inc  = {1'b0, r_col} + 9'd1;
    assign row_inc  = {1'b0, r_row} + 9'd1;
    assign wrap     = (col_inc >= {1'b0, eff_cols});
    assign bottom   = (row_inc >= {1'b0, eff_rows});
    assign row_down = bottom ? (eff_rows - 8'd1) : row_inc[7:0];
    assign ph_inc   = (r_tab_ph == TW'(tcce_pkg::TAB_WIDTH - 1)) ? '0 : (r_tab_ph + TW'(1));

    // Decode the incoming character
    assign is_nl  = (i_char_code == tcce_pkg::CH_NEWLINE);
    assign is_cr  = (i_char_code == tcce_pkg::CH_RETURN);
    assign is_tab = (i_char_code == tcce_pkg::CH_TAB);

    assign out_free = !r_res_valid || o_res.ready;

    // Status towards the controller
    always_comb begin
        o_st.enable     = r_enable;
        o_st.out_free   = out_free;
        o_st.is_newline = is_nl;
        o_st.is_write   = !is_nl && !is_cr;
        o_st.wrap       = wrap;
        o_st.bottom     = bottom;
        o_st.tab_one    = (r_tab_left == TW'(1));
        o_st.tab_zero   = (r_tab_left == '0);
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= tcce_pkg::RST_ENABLE;
            r_columns <= tcce_pkg::RST_COLUMNS;
            r_rows    <= tcce_pkg::RST_ROWS;
            r_color   <= tcce_pkg::RST_COLOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcce_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                tcce_pkg::CFG_COLUMNS: r_columns <= i_cfg_data[7:0];
                tcce_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[7:0];
                tcce_pkg::CFG_COLOR:   r_color   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next cursor and tab counter
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_tab_ph   = r_tab_ph;
        n_tab_left = r_tab_left;
        priority if (i_cmd.load_item) begin
            if (is_nl) begin
                n_col      = 8'd0;
                n_tab_ph   = '0;
                n_row      = row_down;
                n_tab_left = '0;
            end else if (is_cr) begin
                n_col      = 8'd0;
                n_tab_ph   = '0;
                n_tab_left = '0;
            end else if (is_tab) begin
                n_tab_left = TW'(tcce_pkg::TAB_WIDTH) - r_tab_ph;
            end else begin
                n_tab_left = TW'(1);
            end
        end else if (i_cmd.emit_cell) begin
            n_tab_left = r_tab_left - TW'(1);
            if (wrap) begin
                n_col    = 8'd0;
                n_tab_ph = '0;
                n_row    = row_down;
            end else begin
                n_col    = col_inc[7:0];
                n_tab_ph = ph_inc;
            end
        end else begin
        end
    end

    // Hold the cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= 8'd0;
            r_row      <= 8'd0;
            r_tab_ph   <= '0;
            r_tab_left <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_tab_ph   <= n_tab_ph;
            r_tab_left <= n_tab_left;
        end
    end

    // Latch the glyph of the accepted character
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_glyph <= is_tab ? tcce_pkg::CH_SPACE : i_char_code;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.emit_cell || i_cmd.emit_scroll) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cell) begin
            r_res_kind  <= tcce_pkg::KIND_CELL;
            r_res_col   <= r_col;
            r_res_row   <= r_row;
            r_res_glyph <= r_glyph;
            r_res_color <= r_color;
            r_res_last  <= !(wrap && bottom) && (r_tab_left == TW'(1));
        end else if (i_cmd.emit_scroll) begin
            r_res_kind  <= tcce_pkg::KIND_SCROLL;
            r_res_col   <= 8'd0;
            r_res_row   <= 8'd0;
            r_res_glyph <= 8'd0;
            r_res_color <= 8'd0;
            r_res_last  <= (r_tab_left == '0);
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.kind  = r_res_kind;
    assign o_res.col   = r_res_col;
    assign o_res.row   = r_res_row;
    assign o_res.glyph = r_res_glyph;
    assign o_res.color = r_res_color;
    assign o_res.last  = r_res_last;

endmodule

`default_nettype wire

[src/tcce_ctrl.sv]
// Controller state machine: accepts characters and sequences cell and scroll results.
`default_nettype none

module tcce_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire tcce_pkg::t_status i_st,
    output tcce_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CELL   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;

    logic [1:0] r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // Issue commands and choose the next state
    always_comb begin
        n_state           = r_state;
        o_cmd.load_item   = 1'b0;
        o_cmd.emit_cell   = 1'b0;
        o_cmd.emit_scroll = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // drop characters while disabled
                if (i_in_valid && i_st.enable) begin
                    o_cmd.load_item = 1'b1;
                    if (i_st.is_newline && i_st.bottom) begin
                        n_state = ST_SCROLL;
                    end else if (i_st.is_write) begin
                        n_state = ST_CELL;
                    end
                end
            end
            ST_CELL: begin
                if (i_st.out_free) begin
                    o_cmd.emit_cell = 1'b1;
                    if (i_st.wrap && i_st.bottom) begin
                        n_state = ST_SCROLL;
                    end else if (i_st.tab_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCROLL: begin
                if (i_st.out_free) begin
                    o_cmd.emit_scroll = 1'b1;
                    n_state = i_st.tab_zero ? ST_IDLE : ST_CELL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one datapath action per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_item, o_cmd.emit_cell, o_cmd.emit_scroll}))
        else $error("controller issued more than one command");

    // Never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_cell || o_cmd.emit_scroll) |-> i_st.out_free)
        else $error("result emitted into a full output register");

    // A cell state always has a cell left to write
    a_cell_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL) |-> !i_st.tab_zero)
        else $error("cell state with no cell left");

    // After the final cell with no scroll, the controller returns to idle
    a_cell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_cell && i_st.tab_one && !(i_st.wrap && i_st.bottom))
        |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after the last cell");

endmodule

`default_nettype wire
